### hw/rtl/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/lbe_pkg.sv
package lbe_pkg;

	localparam int LABEL_W        = 32;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 16;
	localparam int LEN_REG_W      = 12;
	localparam int CNT_REG_W      = 16;
	localparam int LINE_LENGTH_RST = 2048;
	localparam int LINE_COUNT_RST  = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_LENGTH = 1'b0,
		REG_LINE_COUNT  = 1'b1
	} cfg_reg_t;

	typedef logic [CNT_REG_W-1:0] line_cnt_t;

endpackage

### hw/rtl/label_boundary_eraser_top.sv
// Output: the result for a pixel is registered when the pixel at the same
//   position one line later (or, for the last line, the matching drain) is accepted.
// One transaction per cycle when not stalled; line store has one write and two read ports.
// Reset: arst_n clears position and line counters and the output valid, and loads
//   line_length and line_count defaults; the line store is not cleared.
`include "assert_macros.svh"

module label_boundary_eraser_top #(
	parameter int MAX_LINE   = 2048,
	parameter int LABEL_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  lbe_pkg::cfg_reg_t               cfg_idx,
	input  logic [lbe_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lbe_pkg::LABEL_W-1:0]     s_tdata,   // label
	input  logic                            s_tuser,   // drain
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lbe_pkg::LABEL_W-1:0]     m_tdata,   // out_label
	output logic                            m_tlast
);
	import lbe_pkg::*;

	localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
	localparam int LW = $clog2(MAX_LINE + 1);
	localparam int SW = LW + 1;
	localparam int DW = 2 * LABEL_BITS;
	localparam int LEN_RST = (MAX_LINE < LINE_LENGTH_RST) ? MAX_LINE : LINE_LENGTH_RST;

	// config
	logic [LW-1:0]        len_q;
	line_cnt_t            cnt_q;
	logic [LEN_REG_W-1:0] len_wr;
	logic [LW-1:0]        len_eff;
	line_cnt_t            cnt_eff;

	assign len_wr = cfg_data[LEN_REG_W-1:0];

	always_comb begin
		priority if (len_wr == '0) begin
			len_eff = LW'(1);
		end else if (int'(len_wr) > MAX_LINE) begin
			len_eff = LW'(MAX_LINE);
		end else begin
			len_eff = LW'(len_wr);
		end
		cnt_eff = (cfg_data == '0) ? CNT_REG_W'(1) : cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LW'(LEN_RST);
			cnt_q <= CNT_REG_W'(LINE_COUNT_RST);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LINE_LENGTH: len_q <= len_eff;
				REG_LINE_COUNT:  cnt_q <= cnt_eff;
			endcase
		end
	end

	// scan control
	logic [AW-1:0]         pos_q, pos_d;
	line_cnt_t             line_q, line_d;
	logic [SW-1:0]         pos_inc;
	logic                  wrap, drain_phase, pixel, early, emit, accept, last;
	logic [LABEL_BITS-1:0] lab;

	assign lab         = s_tdata[LABEL_BITS-1:0];
	assign pos_inc     = SW'(pos_q) + SW'(1);
	assign wrap        = pos_inc >= SW'(len_q);
	assign drain_phase = line_q >= cnt_q;
	assign pixel       = !s_tuser && !drain_phase;
	assign early       = s_tuser && !drain_phase;
	assign emit        = drain_phase || (pixel && line_q != '0);
	assign last        = drain_phase && wrap;
	assign s_tready    = !m_tvalid || m_tready;
	assign accept      = s_tvalid && s_tready;

	always_comb begin
		pos_d  = pos_q;
		line_d = line_q;
		if (accept && !early) begin
			priority if (last) begin
				pos_d  = '0;
				line_d = '0;
			end else if (wrap) begin
				pos_d  = '0;
				line_d = line_q + CNT_REG_W'(1);
			end else begin
				pos_d = pos_inc[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			line_q <= '0;
		end else begin
			pos_q  <= pos_d;
			line_q <= line_d;
		end
	end

	// line store: entry = {middle line label, older line label}
	logic [DW-1:0]         mem [MAX_LINE];
	logic [DW-1:0]         rda_q, rdb_q, wdata;
	logic [AW-1:0]         rdb_addr;
	logic [SW-1:0]         nxt;
	logic                  we;
	logic [LABEL_BITS-1:0] cur_mid, cur_old, right, left_q;

	assign cur_mid  = rda_q[DW-1:LABEL_BITS];
	assign cur_old  = rda_q[LABEL_BITS-1:0];
	assign right    = rdb_q[DW-1:LABEL_BITS];
	assign nxt      = SW'(pos_d) + SW'(1);
	assign rdb_addr = (nxt < SW'(MAX_LINE)) ? nxt[AW-1:0] : '0;
	assign we       = accept && !early;
	assign wdata    = {(pixel ? lab : cur_mid), cur_mid};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[pos_q] <= wdata;
			left_q     <= cur_mid;
		end
		rda_q <= (we && pos_q == pos_d)    ? wdata : mem[pos_d];
		rdb_q <= (we && pos_q == rdb_addr) ? wdata : mem[rdb_addr];
	end

	// neighborhood decision
	logic                  across_in, along_in, ap, bp, a_eq, b_eq, border;
	logic [LABEL_BITS-1:0] res;

	always_comb begin
		across_in = pixel && line_q >= CNT_REG_W'(2);
		along_in  = pos_q != '0 && !wrap;
		ap        = across_in && cur_old != '0 && lab != '0;
		bp        = along_in && left_q != '0 && right != '0;
		a_eq      = cur_old == lab;
		b_eq      = left_q == right;
		border    = (ap && !a_eq) || (bp && !b_eq) ||
			(ap && bp && a_eq && b_eq && cur_old != left_q);
		priority if (cur_mid != '0) begin
			res = cur_mid;
		end else if (border) begin
			res = '0;
		end else if (bp && b_eq) begin
			res = left_q;
		end else if (ap && a_eq) begin
			res = cur_old;
		end else begin
			res = '0;
		end
	end

	// result register
	logic                  out_valid_q, out_last_q;
	logic [LABEL_BITS-1:0] out_label_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_label_q <= res;
			out_last_q  <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = LABEL_W'(out_label_q);
	assign m_tlast  = out_last_q;

	`ASSERT_IMPL(a_frame_end_clear, clk, arst_n, m_tvalid && m_tlast, pos_q == '0 && line_q == '0, "counters not cleared after frame end")
	`ASSERT_NEXT(a_early_drain_idle, clk, arst_n, accept && early, $stable(pos_q) && $stable(line_q) && !m_tvalid, "early drain changed state")
	`ASSERT_NEXT(a_first_line_silent, clk, arst_n, accept && pixel && line_q == '0, !m_tvalid, "first line produced a result")

endmodule
